[src/skc_pkg.sv]
// Package for the skeleton neighbor classifier: field widths, register indexes,
// reset values, classification thresholds and the classification struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skc_pkg;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned COORD_W     = 10;
    localparam int unsigned ROW_W       = 10;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned TOTAL_W     = 20;
    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned WIN_W       = 9;
    localparam int unsigned CENTER_BIT  = 4;
    localparam int unsigned LINE_W      = 2;

    localparam int unsigned SIZE_MIN   = 3;
    localparam int unsigned HEIGHT_MAX = 1024;
    localparam int unsigned BRANCH_MIN = 3;
    localparam int unsigned TIP_COUNT  = 1;
    localparam int unsigned KEEP_MIN   = 2;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX    = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_reg_index;

    typedef struct packed {
        logic               center_set;
        logic [COUNT_W-1:0] neighbor_count;
        logic               is_branch;
        logic               is_tip;
        logic               kept;
    } t_class;

endpackage

`default_nettype wire

[src/skc_line_store.sv]
// Line store for the two previous image rows, one bit of each row per column.
// Registered read port and a separate write port; uses skc_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module skc_line_store
    import skc_pkg::*;
#(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [LINE_W-1:0] o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [LINE_W-1:0] i_wr_data
);

    logic [LINE_W-1:0] r_mem [DEPTH];
    logic [LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[src/skc_window_class.sv]
// Classification of the center of a 3x3 window: neighbor count and the
// branch, tip and keep flags. Uses skc_pkg for thresholds and t_class.
`timescale 1ns / 1ps
`default_nettype none

module skc_window_class
    import skc_pkg::*;
(
    input  wire logic [WIN_W-1:0] i_window,
    output t_class                o_class
);

    logic [COUNT_W-1:0] count;
    logic               center;

    always_comb begin
        count = '0;
        for (int i = 0; i < WIN_W; i++) begin
            if (i != CENTER_BIT) begin
                count = count + COUNT_W'(i_window[i]);
            end
        end
        center = i_window[CENTER_BIT];

        o_class.center_set     = center;
        o_class.neighbor_count = count;
        o_class.is_branch      = center && (count >= COUNT_W'(BRANCH_MIN));
        o_class.is_tip         = center && (count == COUNT_W'(TIP_COUNT));
        o_class.kept           = center && (count >= COUNT_W'(KEEP_MIN));
    end

endmodule

`default_nettype wire

[src/skeleton_neighbor_classifier.sv]
// Top level of the skeleton neighbor classifier: position counters, line store,
// window register, frame totals and output register. Uses skc_pkg,
// skc_line_store and skc_window_class.
//
//   channel  direction  handshake                 payload
//   cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//   pixel    in         i_in_valid / o_in_stall    i_pixel_value
//   result   out        o_out_valid / i_out_stall  center, count, flags, totals
//
// One pixel beat is taken every cycle while o_in_stall is low. The line store
// read is registered, so each pixel is held in the window stage before its result
// is loaded into the output register.
// Reset is synchronous and active low; the line store is not cleared.
// A stalled result holds the window stage; further pixels are stalled only then.
`timescale 1ns / 1ps
`default_nettype none

module skeleton_neighbor_classifier
    import skc_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [PIX_W-1:0]       i_pixel_value,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [COORD_W-1:0]          o_center_x,
    output logic [COORD_W-1:0]          o_center_y,
    output logic                        o_center_set,
    output logic [COUNT_W-1:0]          o_neighbor_count,
    output logic                        o_is_branch,
    output logic                        o_is_tip,
    output logic                        o_kept_after_prune,
    output logic [TOTAL_W-1:0]          o_branch_total,
    output logic [TOTAL_W-1:0]          o_tip_total,
    output logic                        o_frame_end
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned CNT_W = $clog2(MAX_WIDTH + 1);

    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic                  r_s1_valid;
    logic                  r_s1_pix;
    logic [COL_W-1:0]      r_s1_col;
    logic [ROW_W-1:0]      r_s1_row;
    logic                  r_s1_has_res;
    logic                  r_s1_frame_last;
    logic [WIN_W-1:0]      r_window;
    logic [TOTAL_W-1:0]    r_branch_cnt;
    logic [TOTAL_W-1:0]    r_tip_cnt;
    logic                  r_out_valid;
    logic [COORD_W-1:0]    r_out_x;
    logic [COORD_W-1:0]    r_out_y;
    t_class                r_out_class;
    logic [TOTAL_W-1:0]    r_out_branch;
    logic [TOTAL_W-1:0]    r_out_tip;
    logic                  r_out_frame_end;

    logic [WIN_W-1:0]      n_window;
    logic [TOTAL_W-1:0]    n_branch_cnt;
    logic [TOTAL_W-1:0]    n_tip_cnt;

    logic [CNT_W-1:0]      eff_width;
    logic [CFG_DATA_W-1:0] eff_height;
    logic                  in_accept;
    logic                  out_free;
    logic                  s1_adv;
    logic                  row_last;
    logic                  frame_last;
    logic                  has_res;
    logic [LINE_W-1:0]     line_rd;
    t_class                cls;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width < CFG_DATA_W'(SIZE_MIN)) begin
            eff_width = CNT_W'(SIZE_MIN);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            eff_width = CNT_W'(MAX_WIDTH);
        end else begin
            eff_width = CNT_W'(r_frame_width);
        end
        if (r_frame_height < CFG_DATA_W'(SIZE_MIN)) begin
            eff_height = CFG_DATA_W'(SIZE_MIN);
        end else if (r_frame_height > CFG_DATA_W'(HEIGHT_MAX)) begin
            eff_height = CFG_DATA_W'(HEIGHT_MAX);
        end else begin
            eff_height = r_frame_height;
        end
    end

    // Handshake.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && (!r_s1_has_res || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Raster position of the incoming pixel.
    assign row_last   = (CNT_W'(r_col) + CNT_W'(1)) >= eff_width;
    assign frame_last = row_last && ((CFG_DATA_W'(r_row) + CFG_DATA_W'(1)) >= eff_height);
    assign has_res    = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (row_last) begin
                r_col <= '0;
                r_row <= frame_last ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Window stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept || (r_s1_valid && !s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pix        <= (i_pixel_value != '0);
            r_s1_col        <= r_col;
            r_s1_row        <= r_row;
            r_s1_has_res    <= has_res;
            r_s1_frame_last <= frame_last;
        end
    end

    skc_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (line_rd),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({r_s1_pix, line_rd[1]})
    );

    assign n_window = {r_s1_pix, line_rd[1], line_rd[0], r_window[WIN_W-1:3]};

    skc_window_class u_window_class (
        .i_window (n_window),
        .o_class  (cls)
    );

    always_comb begin
        n_branch_cnt = r_branch_cnt;
        n_tip_cnt    = r_tip_cnt;
        if (r_s1_has_res && cls.is_branch && (r_branch_cnt != TOTAL_MAX)) begin
            n_branch_cnt = r_branch_cnt + TOTAL_W'(1);
        end
        if (r_s1_has_res && cls.is_tip && (r_tip_cnt != TOTAL_MAX)) begin
            n_tip_cnt = r_tip_cnt + TOTAL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= '0;
            r_branch_cnt <= '0;
            r_tip_cnt    <= '0;
        end else if (s1_adv) begin
            r_window     <= n_window;
            r_branch_cnt <= r_s1_frame_last ? '0 : n_branch_cnt;
            r_tip_cnt    <= r_s1_frame_last ? '0 : n_tip_cnt;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (s1_adv && r_s1_has_res) || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_has_res) begin
            r_out_x         <= COORD_W'(32'(r_s1_col) - 32'd1);
            r_out_y         <= r_s1_row - ROW_W'(1);
            r_out_class     <= cls;
            r_out_branch    <= n_branch_cnt;
            r_out_tip       <= n_tip_cnt;
            r_out_frame_end <= r_s1_frame_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_center_x         = r_out_x;
    assign o_center_y         = r_out_y;
    assign o_center_set       = r_out_class.center_set;
    assign o_neighbor_count   = r_out_class.neighbor_count;
    assign o_is_branch        = r_out_class.is_branch;
    assign o_is_tip           = r_out_class.is_tip;
    assign o_kept_after_prune = r_out_class.kept;
    assign o_branch_total     = r_out_branch;
    assign o_tip_total        = r_out_tip;
    assign o_frame_end        = r_out_frame_end;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s1_has_res && r_out_valid && i_out_stall))
        else $error("pixel stalled without a blocked result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_frame_last) |=> (r_branch_cnt == '0 && r_tip_cnt == '0))
        else $error("frame totals not cleared after the last pixel");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_col) && $stable(r_s1_row)))
        else $error("window stage lost a held pixel");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_center_set) |->
            (o_kept_after_prune == (o_neighbor_count >= 4'd2)))
        else $error("keep flag disagrees with neighbor count");

endmodule

`default_nettype wire
